// ----- hdl/base64_stream_decoder_macros.svh -----
// Assertion macros for the base64 stream decoder, used by the decode engine.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Checked only while out of reset.
`define B64SD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define B64SD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/b64sd_pkg.sv -----
// Types and constants shared by the base64 stream decoder modules.
package b64sd_pkg;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] result_kind;
    } t_out;

    // One classified character as the back end sees it.
    typedef struct packed {
        logic [5:0] sextet;
        logic       is_stop;
        logic       is_pad;
        logic       is_eoi;
    } t_token;

    typedef struct packed {
        logic   push;
        t_token token;
    } t_q_wr;

    typedef struct packed {
        logic   valid;
        t_token token;
    } t_q_rd;

endpackage

// ----- hdl/b64sd_queue.sv -----
// Short token queue between the classifier and the decode engine.
module b64sd_queue
    import b64sd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    output logic  o_full,
    output t_q_rd o_rd,
    input  logic  i_pop
);

    t_token              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;
    logic                push_en;
    logic                pop_en;

    assign o_full   = (r_count == QCNT_W'(QDEPTH));
    assign push_en  = i_wr.push && !o_full;
    assign pop_en   = i_pop && (r_count != '0);

    assign o_rd.valid = (r_count != '0);
    assign o_rd.token = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push_en && !pop_en) begin
            n_count = r_count + 1'b1;
        end else if (pop_en && !push_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr_ptr] <= i_wr.token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// ----- hdl/b64sd_front.sv -----
// Input side: takes characters and classifies them into tokens for the queue.
module b64sd_front
    import b64sd_pkg::*;
(
    input  logic  i_in_valid,
    input  t_in   i_in_data,
    output logic  o_in_stall,
    input  logic  i_q_full,
    output t_q_wr o_q_wr
);

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] s;
        s = 6'd0;
        case (c) inside
            [8'h41:8'h5A]: s = 6'(c - 8'h41);
            [8'h61:8'h7A]: s = 6'(c - 8'h61 + 8'd26);
            [8'h30:8'h39]: s = 6'(c - 8'h30 + 8'd52);
            CHAR_PLUS:     s = 6'd62;
            CHAR_SLASH:    s = 6'd63;
            default:       s = 6'd0;
        endcase
        return s;
    endfunction

    logic blank;

    // Tab through carriage return, plus space
    assign blank = (i_in_data.char_code == CHAR_SPACE) ||
                   ((i_in_data.char_code >= 8'd9) && (i_in_data.char_code <= 8'd13));

    assign o_in_stall = i_q_full;

    assign o_q_wr.push         = i_in_valid && !i_q_full;
    assign o_q_wr.token.sextet = sextet_of(i_in_data.char_code);
    assign o_q_wr.token.is_eoi = i_in_data.end_of_input;
    assign o_q_wr.token.is_stop = i_in_data.end_of_input || blank;
    assign o_q_wr.token.is_pad = !i_in_data.end_of_input && (i_in_data.char_code == CHAR_PAD);

endmodule

// ----- hdl/b64sd_back.sv -----
// Decode engine: quad state machine, bit accumulator and output register.
`include "base64_stream_decoder_macros.svh"

module b64sd_back
    import b64sd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_rd i_q_rd,
    output logic  o_pop,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_out  o_out_data
);

    typedef enum logic [5:0] {
        PH_Q0   = 6'b000001,
        PH_Q1   = 6'b000010,
        PH_Q2   = 6'b000100,
        PH_Q3   = 6'b001000,
        PH_PAD2 = 6'b010000,
        PH_TAIL = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [23:0] r_acc, n_acc;
    logic        r_open, n_open;
    logic        r_err, n_err;
    logic        r_out_valid;
    t_out        r_out;
    logic        has_res;
    t_out        res;
    t_token      tok;

    assign tok         = i_q_rd.token;
    assign o_pop       = i_q_rd.valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_phase         = r_phase;
        n_acc           = r_acc;
        n_open          = r_open;
        n_err           = r_err;
        has_res         = 1'b0;
        res.data_byte   = '0;
        res.result_kind = KIND_BYTE;
        if (o_pop) begin
            if (r_err) begin
                has_res         = 1'b1;
                res.result_kind = KIND_ERROR;
            end else begin
                unique case (r_phase)
                    PH_Q0: begin
                        if (tok.is_stop) begin
                            if (r_open || tok.is_eoi) begin
                                has_res         = 1'b1;
                                res.result_kind = KIND_END;
                                n_open          = 1'b0;
                                n_acc           = '0;
                            end
                        end else begin
                            n_open  = 1'b1;
                            n_acc   = {tok.sextet, 18'd0};
                            n_phase = PH_Q1;
                        end
                    end
                    PH_Q1: begin
                        if (tok.is_stop) begin
                            n_err           = 1'b1;
                            has_res         = 1'b1;
                            res.result_kind = KIND_ERROR;
                        end else begin
                            n_acc[17:12]  = tok.sextet;
                            n_phase       = PH_Q2;
                            has_res       = 1'b1;
                            res.data_byte = {r_acc[23:18], tok.sextet[5:4]};
                        end
                    end
                    PH_Q2: begin
                        if (tok.is_stop) begin
                            n_err           = 1'b1;
                            has_res         = 1'b1;
                            res.result_kind = KIND_ERROR;
                        end else if (tok.is_pad) begin
                            n_phase = PH_PAD2;
                        end else begin
                            n_acc[11:6]   = tok.sextet;
                            n_phase       = PH_Q3;
                            has_res       = 1'b1;
                            res.data_byte = {r_acc[15:12], tok.sextet[5:2]};
                        end
                    end
                    PH_Q3: begin
                        if (tok.is_stop) begin
                            n_err           = 1'b1;
                            has_res         = 1'b1;
                            res.result_kind = KIND_ERROR;
                        end else if (tok.is_pad) begin
                            n_phase = PH_TAIL;
                        end else begin
                            n_acc[5:0]    = tok.sextet;
                            n_phase       = PH_Q0;
                            has_res       = 1'b1;
                            res.data_byte = {r_acc[7:6], tok.sextet};
                        end
                    end
                    PH_PAD2: begin
                        if (tok.is_stop || !tok.is_pad) begin
                            n_err           = 1'b1;
                            has_res         = 1'b1;
                            res.result_kind = KIND_ERROR;
                        end else begin
                            n_phase = PH_TAIL;
                        end
                    end
                    PH_TAIL: begin
                        has_res = 1'b1;
                        if (tok.is_stop) begin
                            res.result_kind = KIND_END;
                            n_phase         = PH_Q0;
                            n_open          = 1'b0;
                            n_acc           = '0;
                        end else begin
                            n_err           = 1'b1;
                            res.result_kind = KIND_ERROR;
                        end
                    end
                    default: begin
                        n_phase         = PH_Q0;
                        n_err           = 1'b1;
                        has_res         = 1'b1;
                        res.result_kind = KIND_ERROR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (o_pop && has_res) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_Q0;
            r_open      <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_open  <= n_open;
            r_err   <= n_err;
            if (o_pop && has_res) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `B64SD_ASSERT(a_err_sticky, i_clk, i_rst_n, r_err |=> r_err, "error flag cleared without reset")
    `B64SD_ASSERT(a_err_result, i_clk, i_rst_n, (r_err && o_pop) |=> (r_out_valid && r_out.result_kind == KIND_ERROR), "non-error result after latched error")
    `B64SD_ASSERT(a_end_closes, i_clk, i_rst_n, (o_pop && has_res && res.result_kind == KIND_END) |=> (!r_open && r_phase == PH_Q0), "stream not closed after end result")
    `B64SD_ASSERT(a_ctrl_zero, i_clk, i_rst_n, (r_out_valid && r_out.result_kind != KIND_BYTE) |-> (r_out.data_byte == 8'd0), "end or error result carries data")
    `B64SD_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !r_out_valid, "output valid after reset")

endmodule

// ----- hdl/base64_stream_decoder.sv -----
// Top level of the base64 stream decoder.
// Decodes a base64 character stream, one character or end-of-input mark per
// transfer, and returns at most one result per character: a decoded byte, an
// end-of-stream mark, or a sticky format error that holds until reset. A
// character is taken every cycle unless the queue is full (the only cause of
// an input stall); it passes the classifier, a 4-entry token queue and the
// decode engine, its token registered in the queue, its result in the output
// register. While a stalled result waits in the output register the engine
// holds and the queue takes up to four more characters before input stalls.
module base64_stream_decoder
    import b64sd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    b64sd_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr)
    );

    b64sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_pop   (q_pop)
    );

    b64sd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_rd      (q_rd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
